// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/blrd_pkg.sv -----
// ---------------------------------------------------------------------------
// blrd_pkg
// Types and constants of the binary load record deframer.
// ---------------------------------------------------------------------------
package blrd_pkg;

  localparam logic [7:0] SOH_BYTE     = 8'h01;
  localparam logic [7:0] BINARY_FLOOR = 8'h7f;
  localparam int         CHUNK_BITS   = 10;  // intermediate checksum every 1024 bytes

  localparam int          CFG_INDEX_W     = 1;
  localparam int          CFG_DATA_W      = 32;
  localparam logic [31:0] MAX_LEN_RESET   = 32'd65536;

  localparam logic [CFG_INDEX_W-1:0] REG_CHECKSUM_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD_LEN = 1'b1;

  // result event codes
  localparam logic [2:0] EV_PAYLOAD     = 3'd0;
  localparam logic [2:0] EV_FRAME_OK    = 3'd1;
  localparam logic [2:0] EV_TERMINATOR  = 3'd2;
  localparam logic [2:0] EV_STREAM_END  = 3'd3;
  localparam logic [2:0] EV_FORMAT_ERR  = 3'd4;
  localparam logic [2:0] EV_TOO_LONG    = 3'd5;
  localparam logic [2:0] EV_MID_CK_BAD  = 3'd6;
  localparam logic [2:0] EV_FINAL_CK_BAD = 3'd7;

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_MIDCK  = 5'b01000,
    PH_FINAL  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  event_res;
    logic [31:0] byte_address;
    logic [7:0]  payload_byte;
    logic [7:0]  expected_checksum;
  } result_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } cfg_write_t;

endpackage

// ----- hw/rtl/blrd_core.sv -----
// ---------------------------------------------------------------------------
// blrd_core
// Frame state, configuration registers and the per-byte decode step.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module blrd_core (
  input  logic                 clk,
  input  logic                 rst,
  input  blrd_pkg::cfg_write_t cfg,
  input  logic                 step,
  input  logic [7:0]           byte_value,
  input  logic                 end_of_stream,
  output blrd_pkg::result_t    res
);

  logic        checksum_enable;
  logic [31:0] max_payload_length;

  blrd_pkg::phase_t phase, phase_next;
  logic [2:0]       header_count, header_count_next;
  logic [31:0]      frame_length, frame_length_next;
  logic [31:0]      frame_address, frame_address_next;
  logic [31:0]      payload_index, payload_index_next;
  logic [7:0]       running_sum, running_sum_next;

  logic [7:0]  expect_ck;
  logic [7:0]  sum_add;
  logic [31:0] index_inc;
  logic [31:0] len_shift;
  logic        ck_bad;

  assign expect_ck = 8'd0 - running_sum;
  assign sum_add   = running_sum + byte_value;
  assign index_inc = payload_index + 32'd1;
  assign len_shift = {frame_length[23:0], byte_value};
  assign ck_bad    = (byte_value != expect_ck) && checksum_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_enable    <= 1'b1;
      max_payload_length <= blrd_pkg::MAX_LEN_RESET;
    end else if (cfg.we) begin
      case (cfg.index)
        blrd_pkg::REG_CHECKSUM_ENABLE: checksum_enable    <= cfg.data[0];
        blrd_pkg::REG_MAX_PAYLOAD_LEN: max_payload_length <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    frame_length_next  = frame_length;
    frame_address_next = frame_address;
    payload_index_next = payload_index;
    running_sum_next   = running_sum;
    res                = '0;

    if (phase != blrd_pkg::PH_HUNT && end_of_stream) begin
      // stream cut inside a frame
      phase_next         = blrd_pkg::PH_HUNT;
      header_count_next  = 3'd0;
      payload_index_next = 32'd0;
      res.valid          = 1'b1;
      res.event_res      = blrd_pkg::EV_FORMAT_ERR;
    end else begin
      case (phase)
        blrd_pkg::PH_HEADER: begin
          running_sum_next  = sum_add;
          header_count_next = header_count + 3'd1;
          if (!header_count[2]) begin
            frame_length_next = len_shift;
          end else begin
            frame_address_next = {frame_address[23:0], byte_value};
          end
          if (header_count == 3'd7) begin
            if (frame_length > max_payload_length) begin
              phase_next         = blrd_pkg::PH_HUNT;
              payload_index_next = 32'd0;
              res.valid          = 1'b1;
              res.event_res      = blrd_pkg::EV_TOO_LONG;
            end else begin
              payload_index_next = 32'd0;
              phase_next = (frame_length == 32'd0) ? blrd_pkg::PH_FINAL : blrd_pkg::PH_DATA;
            end
          end
        end
        blrd_pkg::PH_MIDCK: begin
          if (ck_bad) begin
            phase_next            = blrd_pkg::PH_HUNT;
            header_count_next     = 3'd0;
            payload_index_next    = 32'd0;
            res.valid             = 1'b1;
            res.event_res         = blrd_pkg::EV_MID_CK_BAD;
            res.expected_checksum = expect_ck;
          end else begin
            phase_next = blrd_pkg::PH_DATA;
          end
        end
        blrd_pkg::PH_DATA: begin
          running_sum_next   = sum_add;
          payload_index_next = index_inc;
          if (index_inc == frame_length) begin
            phase_next = blrd_pkg::PH_FINAL;
          end else if (index_inc[blrd_pkg::CHUNK_BITS-1:0] == '0) begin
            phase_next = blrd_pkg::PH_MIDCK;
          end
          res.valid        = 1'b1;
          res.event_res    = blrd_pkg::EV_PAYLOAD;
          res.byte_address = frame_address + payload_index;
          res.payload_byte = byte_value;
        end
        blrd_pkg::PH_FINAL: begin
          phase_next         = blrd_pkg::PH_HUNT;
          header_count_next  = 3'd0;
          payload_index_next = 32'd0;
          res.valid          = 1'b1;
          if (ck_bad) begin
            res.event_res         = blrd_pkg::EV_FINAL_CK_BAD;
            res.expected_checksum = expect_ck;
          end else if (frame_length == 32'd0) begin
            res.event_res = blrd_pkg::EV_TERMINATOR;
          end else begin
            res.event_res = blrd_pkg::EV_FRAME_OK;
          end
        end
        default: begin
          // hunting, and any stray phase code
          phase_next = blrd_pkg::PH_HUNT;
          if (end_of_stream) begin
            res.valid     = 1'b1;
            res.event_res = blrd_pkg::EV_STREAM_END;
          end else if (byte_value == blrd_pkg::SOH_BYTE) begin
            phase_next         = blrd_pkg::PH_HEADER;
            header_count_next  = 3'd0;
            running_sum_next   = 8'd0;
            frame_length_next  = 32'd0;
            frame_address_next = 32'd0;
            payload_index_next = 32'd0;
          end else if (byte_value >= blrd_pkg::BINARY_FLOOR) begin
            res.valid     = 1'b1;
            res.event_res = blrd_pkg::EV_FORMAT_ERR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= blrd_pkg::PH_HUNT;
      header_count  <= 3'd0;
      frame_length  <= 32'd0;
      frame_address <= 32'd0;
      payload_index <= 32'd0;
      running_sum   <= 8'd0;
    end else if (step) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      frame_length  <= frame_length_next;
      frame_address <= frame_address_next;
      payload_index <= payload_index_next;
      running_sum   <= running_sum_next;
    end
  end

  `ASSERT_CLK(a_hunt_clean, clk, rst,
    (phase == blrd_pkg::PH_HUNT) |-> (header_count == 3'd0 && payload_index == 32'd0),
    "counters not cleared while hunting")
  `ASSERT_CLK(a_data_in_range, clk, rst,
    (phase == blrd_pkg::PH_DATA) |-> (payload_index < frame_length),
    "payload index past frame length")
  `ASSERT_CLK(a_midck_boundary, clk, rst,
    (phase == blrd_pkg::PH_MIDCK) |->
      (payload_index[blrd_pkg::CHUNK_BITS-1:0] == '0 && payload_index != 32'd0),
    "intermediate checksum off a chunk boundary")

endmodule

// ----- hw/rtl/binary_load_record_deframer_top.sv -----
// ---------------------------------------------------------------------------
// binary_load_record_deframer_top
// Cuts a byte stream into binary load frames and emits addressed payload.
// ---------------------------------------------------------------------------
// Usage:
//   Input beats carry one file byte in s_tdata[7:0]; s_tuser high marks the
//   end of the stream instead (the byte is then ignored). Every input beat
//   produces zero or one output beat: a payload byte with its load address,
//   or a frame / stream status event coded in m_tuser.
//   Path: each beat passes the input register, then the result register;
//   m_tvalid rises once the result register takes the decode result.
//   Throughput: one byte per cycle while m_tready stays high, bounded
//   only by the single decode step between the two registers.
//   Stall: while a result waits on a low m_tready the result register holds,
//   the input register takes at most one more beat, then s_tready stays low.
//   Reset (rst, synchronous) empties both registers, returns the framer to
//   hunting for SOH and loads checksum_enable = 1, max_payload_length =
//   65536. Write configuration through cfg_we/cfg_index/cfg_data only when
//   the block is idle.
// ---------------------------------------------------------------------------
module binary_load_record_deframer_top (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [blrd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [blrd_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] byte_value
  input  logic                               s_tuser,   // [0] end_of_stream
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,   // [31:0] byte_address,
                                                        // [39:32] payload_byte,
                                                        // [47:40] expected_checksum
  output logic [2:0]                         m_tuser    // [2:0] event_res
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;

  // result register
  logic              out_valid;
  blrd_pkg::result_t out_res;

  blrd_pkg::result_t    res;
  blrd_pkg::cfg_write_t cfg;
  logic                 advance;

  // the decode stage moves whenever the result register is free or drains
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // capture payload on every accepted beat
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eos  <= s_tuser;
    end
  end

  blrd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (in_valid && advance),
    .byte_value    (in_byte),
    .end_of_stream (in_eos),
    .res           (res)
  );

  // drop the beat when the step produced no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.event_res;
  assign m_tdata  = {out_res.expected_checksum, out_res.payload_byte, out_res.byte_address};

endmodule
